// ===== src/fragment_fec_decoder_defines.svh =====
// ---------------------------------------------------------------------------
// Fragment FEC decoder assertion macros
// Shared property wrappers for the port checker.
// ---------------------------------------------------------------------------
`ifndef FRAGMENT_FEC_DECODER_DEFINES_SVH
`define FRAGMENT_FEC_DECODER_DEFINES_SVH

// clocked property, masked while reset is high
`define FFD_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// clocked property, checked during reset as well
`define FFD_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== src/ffd_pkg.sv =====
// ---------------------------------------------------------------------------
// Fragment FEC decoder package
// Field widths, constants, controller states and command/status groups.
// ---------------------------------------------------------------------------
package ffd_pkg;

   localparam int DEF_MAX_FRAGS      = 256;
   localparam int DEF_MAX_FRAG_BYTES = 32;

   localparam int INDEX_W       = 16;
   localparam int DATA_W        = 8;
   localparam int FRAG_COUNT_W  = 9;
   localparam int FRAG_BYTES_W  = 6;
   localparam int MISSING_W     = 9;
   localparam int CSR_INDEX_W   = 1;
   localparam int CSR_DATA_W    = 9;

   localparam logic [CSR_INDEX_W-1:0] CSR_FRAG_COUNT = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] CSR_FRAG_BYTES = 1'b1;

   // seed 1 + 1001 * index stays below 2^26, and so does every later state
   localparam int SEED_W    = 26;
   localparam int SEED_MULT = 1001;
   localparam int SEED_ADD  = 1;
   localparam int PRBS_TAP  = 5;
   localparam int PRBS_TOP  = 22;
   localparam int MBIT_W    = $clog2(SEED_W);

   function automatic logic [SEED_W-1:0] prbs_next(input logic [SEED_W-1:0] x);
      logic [SEED_W-1:0] fb;
      fb = SEED_W'(x[0] ^ x[PRBS_TAP]) << PRBS_TOP;
      return (x >> 1) + fb;
   endfunction

   typedef enum logic [3:0] {
      S_IDLE,
      S_BUILD,
      S_STEP,
      S_MOD,
      S_SET,
      S_SCAN,
      S_ROW_XOR,
      S_DAT_RD,
      S_DAT_XOR,
      S_STORE_ROW,
      S_STORE_DAT,
      S_REPORT
   } state_type;

   typedef struct packed {
      logic accept;
      logic build;
      logic seed_step;
      logic mod_step;
      logic pick_set;
      logic scan;
      logic row_xor;
      logic dat_xor;
      logic store_row;
      logic store_dat;
      logic report;
   } cmd_type;

   typedef struct packed {
      logic idx_small;
      logic picks_zero;
      logic picks_last;
      logic mod_last;
      logic scan_done;
      logic scan_hit;
      logic found;
      logic byte_last;
      logic store_last;
      logic rsp_free;
   } status_type;

endpackage

// ===== src/fragment_fec_decoder.sv =====
// Sequence: a byte without the last mark is taken in idle; a closing byte runs
//   the row build, n/2 parity picks (none for an uncoded fragment), the
//   elimination sweep, the row store if a free row was found, and the report.
// Throughput: one fragment at a time, set by the bit-serial remainder unit and
//   the sweep (one row per cycle, held on a hit); no new byte while it runs.
// Reset: synchronous; clears row valid bits, fill count, buffer and result valid.
// ---------------------------------------------------------------------------
// Fragment FEC decoder top level
// Joins the controller and the datapath; accepts bytes and reports fragments.
// ---------------------------------------------------------------------------
module fragment_fec_decoder
   import ffd_pkg::*;
#(
   parameter int MAX_FRAGS      = DEF_MAX_FRAGS,
   parameter int MAX_FRAG_BYTES = DEF_MAX_FRAG_BYTES
)(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    csr_valid,
   output logic                    csr_ready,
   input  logic [CSR_INDEX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0]   csr_wdata,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  logic [INDEX_W-1:0]      req_fragment_index,
   input  logic [DATA_W-1:0]       req_data_byte,
   input  logic                    req_last_byte,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output logic [INDEX_W-1:0]      rsp_echo_index,
   output logic                    rsp_outcome,
   output logic [MISSING_W-1:0]    rsp_missing_count,
   output logic                    rsp_complete
);

   cmd_type    cmd;
   status_type status;

   assign csr_ready = 1'b1;

   ffd_ctrl u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_last_byte (req_last_byte),
      .req_ready     (req_ready),
      .status        (status),
      .cmd           (cmd)
   );

   ffd_datapath #(
      .MAX_FRAGS      (MAX_FRAGS),
      .MAX_FRAG_BYTES (MAX_FRAG_BYTES)
   ) u_dp (
      .clock              (clock),
      .reset              (reset),
      .csr_valid          (csr_valid),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata),
      .req_fragment_index (req_fragment_index),
      .req_data_byte      (req_data_byte),
      .req_last_byte      (req_last_byte),
      .rsp_ready          (rsp_ready),
      .rsp_valid          (rsp_valid),
      .rsp_echo_index     (rsp_echo_index),
      .rsp_outcome        (rsp_outcome),
      .rsp_missing_count  (rsp_missing_count),
      .rsp_complete       (rsp_complete),
      .cmd                (cmd),
      .status             (status)
   );

endmodule

// ===== src/ffd_ctrl.sv =====
// ---------------------------------------------------------------------------
// Fragment FEC decoder controller
// Sequences row build, elimination sweep, row store and report.
// ---------------------------------------------------------------------------
module ffd_ctrl
   import ffd_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   input  logic       req_last_byte,
   output logic       req_ready,
   input  status_type status,
   output cmd_type    cmd
);

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_valid && req_last_byte) state_in = S_BUILD;
         end
         S_BUILD: begin
            if (status.idx_small || status.picks_zero) state_in = S_SCAN;
            else state_in = S_STEP;
         end
         S_STEP: state_in = S_MOD;
         S_MOD: begin
            if (status.mod_last) state_in = S_SET;
         end
         S_SET: begin
            if (status.picks_last) state_in = S_SCAN;
            else state_in = S_STEP;
         end
         S_SCAN: begin
            if (status.scan_done) begin
               state_in = status.found ? S_STORE_ROW : S_REPORT;
            end else if (status.scan_hit) begin
               state_in = S_ROW_XOR;
            end
         end
         S_ROW_XOR: state_in = S_DAT_RD;
         S_DAT_RD: state_in = S_DAT_XOR;
         S_DAT_XOR: begin
            state_in = status.byte_last ? S_SCAN : S_DAT_RD;
         end
         S_STORE_ROW: state_in = S_STORE_DAT;
         S_STORE_DAT: begin
            if (status.store_last) state_in = S_REPORT;
         end
         S_REPORT: begin
            if (status.rsp_free) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         S_IDLE: begin
            req_ready  = 1'b1;
            cmd.accept = req_valid;
         end
         S_BUILD:     cmd.build     = 1'b1;
         S_STEP:      cmd.seed_step = 1'b1;
         S_MOD:       cmd.mod_step  = 1'b1;
         S_SET:       cmd.pick_set  = 1'b1;
         S_SCAN:      cmd.scan      = 1'b1;
         S_ROW_XOR:   cmd.row_xor   = 1'b1;
         S_DAT_XOR:   cmd.dat_xor   = 1'b1;
         S_STORE_ROW: cmd.store_row = 1'b1;
         S_STORE_DAT: cmd.store_dat = 1'b1;
         S_REPORT:    cmd.report    = status.rsp_free;
         default:     cmd           = '0;
      endcase
   end

endmodule

// ===== src/ffd_datapath.sv =====
// ---------------------------------------------------------------------------
// Fragment FEC decoder datapath
// Payload buffer, coefficient row, PRBS and remainder unit, row and data stores.
// ---------------------------------------------------------------------------
module ffd_datapath
   import ffd_pkg::*;
#(
   parameter int MAX_FRAGS      = DEF_MAX_FRAGS,
   parameter int MAX_FRAG_BYTES = DEF_MAX_FRAG_BYTES
)(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    csr_valid,
   input  logic [CSR_INDEX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0]   csr_wdata,
   input  logic [INDEX_W-1:0]      req_fragment_index,
   input  logic [DATA_W-1:0]       req_data_byte,
   input  logic                    req_last_byte,
   input  logic                    rsp_ready,
   output logic                    rsp_valid,
   output logic [INDEX_W-1:0]      rsp_echo_index,
   output logic                    rsp_outcome,
   output logic [MISSING_W-1:0]    rsp_missing_count,
   output logic                    rsp_complete,
   input  cmd_type                 cmd,
   output status_type              status
);

   localparam int NW  = $clog2(MAX_FRAGS + 1);
   localparam int RW  = $clog2(MAX_FRAGS);
   localparam int NBW = $clog2(MAX_FRAG_BYTES + 1);
   localparam int KW  = (MAX_FRAG_BYTES > 1) ? $clog2(MAX_FRAG_BYTES) : 1;
   localparam int SD  = MAX_FRAGS * MAX_FRAG_BYTES;
   localparam int SAW = $clog2(SD);

   logic [FRAG_COUNT_W-1:0] frag_count_ff;
   logic [FRAG_BYTES_W-1:0] frag_bytes_ff;
   logic [NW-1:0]           n_val;
   logic [NBW-1:0]          nb_val;
   logic [NW-1:0]           picks_total;

   logic [DATA_W-1:0]       buf_ff [MAX_FRAG_BYTES];
   logic [NBW-1:0]          pos_ff;
   logic [INDEX_W-1:0]      idx_ff;
   logic [MAX_FRAGS-1:0]    coef_ff;
   logic [SEED_W-1:0]       seed_ff, seed_in;
   logic [NW-1:0]           rem_ff;
   logic [NW:0]             rem_t;
   logic [NW:0]             rem_in;
   logic [MBIT_W-1:0]       mbit_ff;
   logic [NW-1:0]           picks_ff;
   logic [NW-1:0]           r_ff;
   logic [KW-1:0]           k_ff;
   logic [MAX_FRAGS-1:0]    valid_ff;
   logic                    found_ff;
   logic [RW-1:0]           target_ff;
   logic [NW-1:0]           rows_filled_ff;
   logic [RW-1:0]           r_idx;

   logic [MAX_FRAGS-1:0]    row_mem [MAX_FRAGS];
   logic [MAX_FRAGS-1:0]    row_q;
   logic [DATA_W-1:0]       store_mem [SD];
   logic [DATA_W-1:0]       store_q;
   logic [SAW-1:0]          rd_addr, wr_addr;

   logic                    rsp_valid_ff;
   logic [INDEX_W-1:0]      echo_ff;
   logic                    outcome_ff;
   logic [MISSING_W-1:0]    missing_ff;
   logic                    complete_ff;
   logic [NW-1:0]           missing_val;
   logic                    complete_val;
   logic                    idx_small;
   logic                    hit;
   logic                    free_row;

   // effective count and byte length
   always_comb begin
      if (frag_count_ff == '0) n_val = NW'(1);
      else if (32'(frag_count_ff) > MAX_FRAGS) n_val = NW'(MAX_FRAGS);
      else n_val = NW'(frag_count_ff);
      if (frag_bytes_ff == '0) nb_val = NBW'(1);
      else if (32'(frag_bytes_ff) > MAX_FRAG_BYTES) nb_val = NBW'(MAX_FRAG_BYTES);
      else nb_val = NBW'(frag_bytes_ff);
   end

   assign picks_total = n_val >> 1;
   assign idx_small   = 32'(idx_ff) < 32'(n_val);
   assign r_idx       = r_ff[RW-1:0];
   assign hit         = coef_ff[r_idx] & valid_ff[r_idx];
   assign free_row    = coef_ff[r_idx] & ~valid_ff[r_idx];
   assign rem_t       = {rem_ff, seed_ff[mbit_ff]};
   assign rem_in      = (rem_t >= {1'b0, n_val}) ? (rem_t - {1'b0, n_val}) : rem_t;
   assign seed_in     = SEED_W'(32'(idx_ff) * 32'(SEED_MULT) + 32'(SEED_ADD));
   assign rd_addr     = SAW'(r_idx) * SAW'(MAX_FRAG_BYTES) + SAW'(k_ff);
   assign wr_addr     = SAW'(target_ff) * SAW'(MAX_FRAG_BYTES) + SAW'(k_ff);
   assign complete_val = rows_filled_ff >= n_val;
   assign missing_val  = complete_val ? '0 : (n_val - rows_filled_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         frag_count_ff <= FRAG_COUNT_W'(1);
         frag_bytes_ff <= FRAG_BYTES_W'(1);
      end else if (csr_valid) begin
         case (csr_index)
            CSR_FRAG_COUNT: frag_count_ff <= csr_wdata[FRAG_COUNT_W-1:0];
            CSR_FRAG_BYTES: frag_bytes_ff <= csr_wdata[FRAG_BYTES_W-1:0];
            default: ;
         endcase
      end
   end

   // payload buffer
   always_ff @(posedge clock) begin
      if (reset || cmd.report) begin
         for (int i = 0; i < MAX_FRAG_BYTES; i++) buf_ff[i] <= '0;
         pos_ff <= '0;
      end else if (cmd.accept) begin
         if (pos_ff < nb_val) begin
            buf_ff[pos_ff[KW-1:0]] <= req_data_byte;
            pos_ff <= pos_ff + NBW'(1);
         end
      end else if (cmd.dat_xor) begin
         buf_ff[k_ff] <= buf_ff[k_ff] ^ store_q;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept && req_last_byte) idx_ff <= req_fragment_index;
   end

   // coefficient row, PRBS and remainder unit
   always_ff @(posedge clock) begin
      if (cmd.build) begin
         coef_ff  <= idx_small ? (MAX_FRAGS'(1) << idx_ff[RW-1:0]) : '0;
         seed_ff  <= seed_in;
         picks_ff <= '0;
      end
      if (cmd.seed_step) begin
         seed_ff <= prbs_next(seed_ff);
         rem_ff  <= '0;
         mbit_ff <= MBIT_W'(SEED_W - 1);
      end
      if (cmd.mod_step) begin
         rem_ff  <= rem_in[NW-1:0];
         mbit_ff <= mbit_ff - MBIT_W'(1);
      end
      if (cmd.pick_set) begin
         coef_ff[rem_ff[RW-1:0]] <= 1'b1;
         picks_ff <= picks_ff + NW'(1);
      end
      if (cmd.row_xor) coef_ff <= coef_ff ^ row_q;
   end

   // sweep counters
   always_ff @(posedge clock) begin
      if (reset) begin
         r_ff     <= '0;
         k_ff     <= '0;
         found_ff <= 1'b0;
      end else begin
         if (cmd.build) begin
            r_ff     <= '0;
            found_ff <= 1'b0;
         end
         if (cmd.scan && (r_ff != n_val)) begin
            if (free_row && !found_ff) begin
               found_ff <= 1'b1;
            end
            if (!hit) r_ff <= r_ff + NW'(1);
         end
         if (cmd.row_xor || cmd.store_row) k_ff <= '0;
         if (cmd.dat_xor) begin
            if (status.byte_last) begin
               k_ff <= '0;
               r_ff <= r_ff + NW'(1);
            end else begin
               k_ff <= k_ff + KW'(1);
            end
         end
         if (cmd.store_dat) begin
            k_ff <= status.store_last ? '0 : k_ff + KW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.scan && (r_ff != n_val) && free_row && !found_ff) target_ff <= r_idx;
   end

   // row store and fragment store
   always_ff @(posedge clock) begin
      row_q <= row_mem[r_idx];
      if (cmd.store_row) row_mem[target_ff] <= coef_ff;
   end

   always_ff @(posedge clock) begin
      store_q <= store_mem[rd_addr];
      if (cmd.store_dat) store_mem[wr_addr] <= buf_ff[k_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff       <= '0;
         rows_filled_ff <= '0;
      end else if (cmd.store_row) begin
         valid_ff[target_ff] <= 1'b1;
         rows_filled_ff      <= rows_filled_ff + NW'(1);
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.report) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.report) begin
         echo_ff     <= idx_ff;
         outcome_ff  <= found_ff;
         missing_ff  <= MISSING_W'(missing_val);
         complete_ff <= complete_val;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_echo_index    = echo_ff;
   assign rsp_outcome       = outcome_ff;
   assign rsp_missing_count = missing_ff;
   assign rsp_complete      = complete_ff;

   always_comb begin
      status.idx_small  = idx_small;
      status.picks_zero = picks_total == '0;
      status.picks_last = (picks_ff + NW'(1)) == picks_total;
      status.mod_last   = mbit_ff == '0;
      status.scan_done  = r_ff == n_val;
      status.scan_hit   = hit;
      status.found      = found_ff;
      status.byte_last  = 32'(k_ff) == 32'(nb_val) - 1;
      status.store_last = 32'(k_ff) == MAX_FRAG_BYTES - 1;
      status.rsp_free   = !rsp_valid_ff || rsp_ready;
   end

endmodule

// ===== src/ffd_checker.sv =====
// ---------------------------------------------------------------------------
// Fragment FEC decoder port checker
// Watches the top level ports for result, intake and reset behaviour.
// ---------------------------------------------------------------------------
`include "fragment_fec_decoder_defines.svh"

module ffd_checker
   import ffd_pkg::*;
(
   input logic                    clock,
   input logic                    reset,
   input logic                    req_valid,
   input logic                    req_ready,
   input logic                    req_last_byte,
   input logic                    rsp_valid,
   input logic                    rsp_ready,
   input logic [INDEX_W-1:0]      rsp_echo_index,
   input logic [MISSING_W-1:0]    rsp_missing_count,
   input logic                    rsp_complete
);

   `FFD_ASSERT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_echo_index) && $stable(rsp_missing_count), "result changed while stalled")
   `FFD_ASSERT(a_complete, clock, reset, rsp_valid |-> (rsp_complete == (rsp_missing_count == '0)), "complete disagrees with missing count")
   `FFD_ASSERT_ALWAYS(a_reset_idle, clock, $past(reset) |-> !rsp_valid, "result valid after reset")
   `FFD_ASSERT(a_one_result, clock, reset, req_valid && req_ready && req_last_byte |=> !req_ready, "fragment close did not stop intake")

endmodule

bind fragment_fec_decoder ffd_checker u_ffd_checker (.*);
